/* rtl/i2cs_pkg.sv */
package i2cs_pkg;

    typedef enum logic [1:0] {
        REQ_OPEN = 2'd0,
        REQ_DONE = 2'd1,
        REQ_TX   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_BUSYING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_BUS_BUSY = 3'd2,
        ST_NACK     = 3'd3,
        ST_REJECT   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ADDR    = 5'b00010,
        PH_WAIT_TX = 5'b00100,
        PH_TX_SENT = 5'b01000,
        PH_RX      = 5'b10000
    } t_phase;

    // R/W bit appended to the slave address
    localparam logic RW_READ  = 1'b1;
    localparam logic RW_WRITE = 1'b0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] slave_addr;
        logic       is_read;
        logic [7:0] byte_count;
        logic       bus_busy;
        logic       slave_acked;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_req_item;

    typedef struct packed {
        t_action    act;
        logic [7:0] bus_byte;
        logic [7:0] read_data;
        logic       read_valid;
        t_status    status;
        logic       last;
    } t_result;

    // Results caused by one item: r1 only used when two is set
    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_pair;

endpackage

/* rtl/i2cs_if.sv */
interface i2cs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] slave_addr;
    logic       is_read;
    logic [7:0] byte_count;
    logic       bus_busy;
    logic       slave_acked;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;

    modport source (
        output valid, req_type, slave_addr, is_read, byte_count, bus_busy,
               slave_acked, rx_byte, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, slave_addr, is_read, byte_count, bus_busy,
               slave_acked, rx_byte, tx_byte,
        output ready
    );
endinterface

interface i2cs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic [2:0] status;
    logic       last;

    modport source (
        output valid, bus_action, bus_byte, read_data, read_valid, status, last,
        input  ready
    );
    modport sink (
        input  valid, bus_action, bus_byte, read_data, read_valid, status, last,
        output ready
    );
endinterface

/* rtl/i2cs_core.sv */
module i2cs_core
    import i2cs_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_req_item i_in,
    output logic      o_in_ready,
    input  logic      i_take,
    output logic      o_push,
    output t_pair     o_pair
);

    logic                  r_in_valid;
    t_req_item             r_in;
    t_phase                r_phase,      n_phase;
    logic                  r_reading,    n_reading;
    logic [COUNT_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [COUNT_BITS-1:0] dec_left;
    logic                  accept;
    logic                  fire;
    t_req                  req;
    t_pair                 pair;

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    assign fire       = r_in_valid && i_take;
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;
    assign req        = t_req'(r_in.req_type);
    assign dec_left   = r_bytes_left - ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in <= i_in;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_reading    = r_reading;
        n_bytes_left = r_bytes_left;
        pair         = '0;
        pair.r0      = '{ACT_NONE, 8'd0, 8'd0, 1'b0, ST_REJECT, 1'b1};
        pair.r1      = '{ACT_NONE, 8'd0, 8'd0, 1'b0, ST_BUSYING, 1'b1};
        pair.two     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (req == REQ_OPEN) begin
                    if (r_in.bus_busy) begin
                        pair.r0.status = ST_BUS_BUSY;
                    end else begin
                        n_reading    = r_in.is_read;
                        n_bytes_left = COUNT_BITS'(r_in.byte_count);
                        n_phase      = PH_ADDR;
                        pair.r0      = '{ACT_START, 8'd0, 8'd0, 1'b0, ST_BUSYING, 1'b0};
                        pair.r1.act  = ACT_SEND;
                        pair.r1.bus_byte = {r_in.slave_addr,
                                            r_in.is_read ? RW_READ : RW_WRITE};
                        pair.two     = 1'b1;
                    end
                end
            end
            PH_ADDR, PH_TX_SENT: begin
                if (req == REQ_DONE) begin
                    pair.r0.status = ST_BUSYING;
                    if (!r_in.slave_acked) begin
                        n_phase        = PH_IDLE;
                        pair.r0.act    = ACT_STOP;
                        pair.r0.status = ST_NACK;
                    end else if (r_bytes_left == '0) begin
                        n_phase        = PH_IDLE;
                        pair.r0.act    = ACT_STOP;
                        pair.r0.status = ST_DONE;
                    end else if (r_phase == PH_ADDR && r_reading) begin
                        n_phase     = PH_RX;
                        pair.r0.act = (r_bytes_left > ONE) ? ACT_RX_ACK : ACT_RX_NACK;
                    end else begin
                        n_phase = PH_WAIT_TX;
                    end
                end
            end
            PH_WAIT_TX: begin
                if (req == REQ_TX) begin
                    n_bytes_left = dec_left;
                    n_phase      = PH_TX_SENT;
                    pair.r0      = '{ACT_SEND, r_in.tx_byte, 8'd0, 1'b0, ST_BUSYING, 1'b1};
                end
            end
            PH_RX: begin
                if (req == REQ_DONE) begin
                    // slave ack is meaningless here: the master drives it
                    n_bytes_left       = dec_left;
                    pair.r0.read_data  = r_in.rx_byte;
                    pair.r0.read_valid = 1'b1;
                    if (dec_left == '0) begin
                        n_phase        = PH_IDLE;
                        pair.r0.act    = ACT_STOP;
                        pair.r0.status = ST_DONE;
                    end else begin
                        pair.r0.act    = (dec_left > ONE) ? ACT_RX_ACK : ACT_RX_NACK;
                        pair.r0.status = ST_BUSYING;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_reading    <= 1'b0;
            r_bytes_left <= '0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_reading    <= n_reading;
            r_bytes_left <= n_bytes_left;
        end
    end

    assign o_push = fire;
    assign o_pair = pair;

    a_two_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && pair.two) |=> (r_phase == PH_ADDR))
        else $error("two-beat result without entering address phase");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && pair.r0.status == ST_REJECT)
        |=> ($stable(r_phase) && $stable(r_reading) && $stable(r_bytes_left)))
        else $error("rejected item altered state");

    a_tx_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == PH_WAIT_TX && req == REQ_TX)
        |=> (r_bytes_left == $past(r_bytes_left) - ONE))
        else $error("write byte count not decremented");

    a_rx_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && pair.r0.read_valid) |-> ($past(r_reading) || r_reading))
        else $error("read data from a write transfer");

endmodule

/* rtl/i2cs_out_buf.sv */
module i2cs_out_buf
    import i2cs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_take,
    output logic  o_valid,
    input  logic  i_ready,
    output t_result o_res
);

    t_pair       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        r_sub;
    t_pair       head;
    logic        beat;
    logic        pop;

    assign head    = r_q[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_sub ? head.r1 : head.r0;
    assign beat    = o_valid && i_ready;
    // entry leaves after its final beat
    assign pop     = beat && (r_sub || !head.two);
    assign o_take  = (r_count != 2'd2) || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (beat) begin
                r_sub <= !pop;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_q[r_wr_ptr] <= i_pair;
        end
    end

endmodule

/* rtl/i2c_master_transfer_sequencer.sv */
// Byte-level I2C master sequencer. Each request beat on i_req is registered, decoded
// against the transfer phase and its results queued for o_res. One request is accepted
// per clock while o_res keeps up; an open transfer on a free bus yields two result
// beats (START, then the address byte), and all other requests one. A request beat
// passes through the input register and then the result queue before its first result
// beat appears. A two-entry result queue decouples o_res back-pressure from request
// intake; a request out of place is answered with status rejected and leaves the
// transfer untouched. COUNT_BITS sets the width of the byte counter.
module i2c_master_transfer_sequencer
    import i2cs_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cs_req_if.sink   i_req,
    i2cs_res_if.source o_res
);

    t_req_item in_item;
    logic      take;
    logic      push;
    t_pair     pair;
    t_result   res;

    assign in_item = '{
        req_type:    i_req.req_type,
        slave_addr:  i_req.slave_addr,
        is_read:     i_req.is_read,
        byte_count:  i_req.byte_count,
        bus_busy:    i_req.bus_busy,
        slave_acked: i_req.slave_acked,
        rx_byte:     i_req.rx_byte,
        tx_byte:     i_req.tx_byte
    };

    i2cs_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in       (in_item),
        .o_in_ready (i_req.ready),
        .i_take     (take),
        .o_push     (push),
        .o_pair     (pair)
    );

    i2cs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .o_take  (take),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.bus_action = res.act;
    assign o_res.bus_byte   = res.bus_byte;
    assign o_res.read_data  = res.read_data;
    assign o_res.read_valid = res.read_valid;
    assign o_res.status     = res.status;
    assign o_res.last       = res.last;

endmodule

/* bench/i2c_master_transfer_sequencer_tb.sv */
`timescale 1ns / 100ps

module i2c_master_transfer_sequencer_tb;
    import i2cs_pkg::*;

    localparam int          CYCLE_LIMIT = 400_000;
    localparam int          PRINT_CAP   = 40;
    localparam logic [1:0]  REQ_BAD     = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cs_req_if req_if ();
    i2cs_res_if res_if ();

    i2c_master_transfer_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted sequencer state
    t_phase     seq_phase   = PH_IDLE;
    logic       seq_reading = 1'b0;
    logic [7:0] seq_left    = '0;

    t_result    expected_results[$];
    int         mismatches       = 0;
    int         cycles           = 0;
    int         sender_idle_pct  = 0;
    int         sink_stall_pct   = 0;
    int         sink_hold_cycles = 0;

    function automatic void queue_result(t_action act, logic [7:0] bus_byte,
                                         logic [7:0] rdata, logic rvalid,
                                         t_status status, logic last);
        t_result r;
        r.act        = act;
        r.bus_byte   = bus_byte;
        r.read_data  = rdata;
        r.read_valid = rvalid;
        r.status     = status;
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // final byte of a read is NACKed
    function automatic t_action next_rx();
        return (seq_left > 8'd1) ? ACT_RX_ACK : ACT_RX_NACK;
    endfunction

    function automatic void predict_beat(t_req_item it);
        logic [7:0] addr_byte;
        addr_byte = {it.slave_addr, it.is_read ? RW_READ : RW_WRITE};
        if (it.req_type == REQ_OPEN && seq_phase == PH_IDLE) begin
            if (it.bus_busy) begin
                queue_result(ACT_NONE, '0, '0, 1'b0, ST_BUS_BUSY, 1'b1);
            end else begin
                seq_reading = it.is_read;
                seq_left    = it.byte_count;
                seq_phase   = PH_ADDR;
                queue_result(ACT_START, '0, '0, 1'b0, ST_BUSYING, 1'b0);
                queue_result(ACT_SEND, addr_byte, '0, 1'b0, ST_BUSYING, 1'b1);
            end
        end else if (it.req_type == REQ_DONE
                     && (seq_phase == PH_ADDR || seq_phase == PH_TX_SENT)) begin
            if (!it.slave_acked) begin
                seq_phase = PH_IDLE;
                queue_result(ACT_STOP, '0, '0, 1'b0, ST_NACK, 1'b1);
            end else if (seq_left == '0) begin
                seq_phase = PH_IDLE;
                queue_result(ACT_STOP, '0, '0, 1'b0, ST_DONE, 1'b1);
            end else if (seq_phase == PH_ADDR && seq_reading) begin
                seq_phase = PH_RX;
                queue_result(next_rx(), '0, '0, 1'b0, ST_BUSYING, 1'b1);
            end else begin
                seq_phase = PH_WAIT_TX;
                queue_result(ACT_NONE, '0, '0, 1'b0, ST_BUSYING, 1'b1);
            end
        end else if (it.req_type == REQ_TX && seq_phase == PH_WAIT_TX) begin
            seq_left  = seq_left - 8'd1;
            seq_phase = PH_TX_SENT;
            queue_result(ACT_SEND, it.tx_byte, '0, 1'b0, ST_BUSYING, 1'b1);
        end else if (it.req_type == REQ_DONE && seq_phase == PH_RX) begin
            // slave_acked means nothing on a receive phase
            seq_left = seq_left - 8'd1;
            if (seq_left == '0) begin
                seq_phase = PH_IDLE;
                queue_result(ACT_STOP, '0, it.rx_byte, 1'b1, ST_DONE, 1'b1);
            end else begin
                queue_result(next_rx(), '0, it.rx_byte, 1'b1, ST_BUSYING, 1'b1);
            end
        end else begin
            queue_result(ACT_NONE, '0, '0, 1'b0, ST_REJECT, 1'b1);
        end
    endfunction

    // Mostly the beat the transfer is waiting for, random payload; some noise.
    function automatic t_req_item pick_beat();
        t_req_item it;
        it = 36'({$urandom, $urandom});
        if ($urandom_range(9) == 0) begin
            return it;
        end
        case (seq_phase)
            PH_IDLE: begin
                it.req_type   = REQ_OPEN;
                it.bus_busy   = ($urandom_range(9) == 0);
                it.byte_count = ($urandom_range(149) == 0) ? 8'($urandom_range(255))
                                                           : 8'($urandom_range(4));
            end
            PH_ADDR, PH_TX_SENT: begin
                it.req_type    = REQ_DONE;
                it.slave_acked = ($urandom_range(15) != 0);
            end
            PH_WAIT_TX: begin
                it.req_type = REQ_TX;
            end
            default: begin
                it.req_type = REQ_DONE;
            end
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic send_beat(input t_req_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
        end
        @(negedge i_clk);
        req_if.req_type    = it.req_type;
        req_if.slave_addr  = it.slave_addr;
        req_if.is_read     = it.is_read;
        req_if.byte_count  = it.byte_count;
        req_if.bus_busy    = it.bus_busy;
        req_if.slave_acked = it.slave_acked;
        req_if.rx_byte     = it.rx_byte;
        req_if.tx_byte     = it.tx_byte;
        req_if.valid       = 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_beat(it);
    endtask

    task automatic send_req(input logic [1:0] req, input logic [6:0] addr,
                            input logic rd, input logic [7:0] cnt, input logic busy,
                            input logic acked, input logic [7:0] rxb,
                            input logic [7:0] txb);
        t_req_item it;
        it.req_type    = req;
        it.slave_addr  = addr;
        it.is_read     = rd;
        it.byte_count  = cnt;
        it.bus_busy    = busy;
        it.slave_acked = acked;
        it.rx_byte     = rxb;
        it.tx_byte     = txb;
        send_beat(it);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        // out of place while idle, and the unused request code
        send_req(REQ_DONE, 7'h12, 1'b0, 8'd3, 1'b0, 1'b1, 8'h11, 8'h22);
        send_req(REQ_TX,   7'h12, 1'b1, 8'd3, 1'b0, 1'b1, 8'h11, 8'h22);
        send_req(REQ_BAD,  7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
        // busy bus refused
        send_req(REQ_OPEN, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00);
        // one-byte write, with stray beats while waiting for data
        send_req(REQ_OPEN, 7'h7F, 1'b0, 8'd1, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_OPEN, 7'h01, 1'b1, 8'd9, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_TX,   7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'hFF);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        // zero-length read stops straight after the address
        send_req(REQ_OPEN, 7'h00, 1'b1, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        // two-byte read, last byte NACKed, ack input ignored on data
        send_req(REQ_OPEN, 7'h55, 1'b1, 8'd2, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_TX,   7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h5A);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'hA5, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        // address NACK
        send_req(REQ_OPEN, 7'h2A, 1'b0, 8'd3, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        // data byte NACK
        send_req(REQ_OPEN, 7'h33, 1'b0, 8'd2, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b1, 8'h00, 8'h00);
        send_req(REQ_TX,   7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        // full count, NACKed on the address
        send_req(REQ_OPEN, 7'h40, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_req(REQ_DONE, 7'h00, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        wait_results_drained();
    endtask

    task automatic test_random(input int beats, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (beats) send_beat(pick_beat());
        wait_results_drained();
    endtask

    // sink held off while beats keep coming, so the result queue fills
    task automatic test_backpressure();
        sender_idle_pct  = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 300;
        repeat (60) send_beat(pick_beat());
        wait_results_drained();
    endtask

    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            res_if.ready = 1'b0;
            sink_hold_cycles--;
        end else begin
            res_if.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat act=%0d status=%0d",
                                          res_if.bus_action, res_if.status));
            end else begin
                want = expected_results.pop_front();
                if (res_if.bus_action !== want.act || res_if.bus_byte !== want.bus_byte
                    || res_if.read_data !== want.read_data
                    || res_if.read_valid !== want.read_valid
                    || res_if.status !== want.status || res_if.last !== want.last) begin
                    report_mismatch($sformatf(
                        "got act=%0d byte=%h rd=%h rv=%b st=%0d last=%b, want %0d %h %h %b %0d %b",
                        res_if.bus_action, res_if.bus_byte, res_if.read_data,
                        res_if.read_valid, res_if.status, res_if.last,
                        want.act, want.bus_byte, want.read_data, want.read_valid,
                        want.status, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = '0;
        req_if.slave_addr  = '0;
        req_if.is_read     = 1'b0;
        req_if.byte_count  = '0;
        req_if.bus_busy    = 1'b0;
        req_if.slave_acked = 1'b0;
        req_if.rx_byte     = '0;
        req_if.tx_byte     = '0;
        res_if.ready       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(500, 0, 0);
        test_random(500, 83, 0);
        test_random(500, 0, 83);
        test_random(500, 23, 23);
        test_backpressure();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
